@@ hdl/ecdcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdcl_pkg
// Shared types and constants for the eight-channel debounce and change latch.
// ----------------------------------------------------------------------------
package ecdcl_pkg;

  // Channels in use (1..8); pins at and above this read as zero.
  localparam int CHANNELS = 8;
  localparam int PIN_W    = 8;
  localparam int WIN_W    = 5;

  // Vote table indexed by the four newest window samples.
  localparam logic [15:0] VOTE_TABLE = 16'hFEE8;

  // APB
  localparam int ADDR_W = 3;
  localparam int APB_DW = 32;
  localparam logic [ADDR_W-1:0] REG_RAW_POLARITY = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DEBOUNCE_EN  = 3'd4;

  // Result packing: filtered, pending, value, mask, padded to 32 bits.
  localparam int RES_W = 32;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_ACK    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic raw_polarity;
    logic debounce_en;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] filtered;
    logic             pending;
    logic [PIN_W-1:0] value;
    logic [PIN_W-1:0] mask;
  } status_t;

endpackage

@@ hdl/eight_channel_debounce_change_latch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_channel_debounce_change_latch
// Eight contact inputs with window debounce and a change-event latch.
// ----------------------------------------------------------------------------
// Output: the result is registered and appears on the master side in the cycle after
//   its input transaction is accepted.
// Throughput: one transaction per cycle while the result side is ready; the state and
//   result registers are refilled in the same cycle the held result is taken.
// Reset: rst_ni async, active low; windows, state, event latch and the result
//   valid flag clear, raw_polarity = 0, debounce_en = 1.
// ----------------------------------------------------------------------------
module eight_channel_debounce_change_latch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pin_levels
  input  logic                          s_axis_tuser,  // [0] opcode
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] filtered_state, [8] event_pending, [16:9] event_value,
  // [24:17] change_mask, [31:25] zero
  output logic [ecdcl_pkg::RES_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ecdcl_pkg::ADDR_W-1:0]  paddr,
  input  logic [ecdcl_pkg::APB_DW-1:0]  pwdata,
  output logic [ecdcl_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  ecdcl_pkg::cfg_t cfg_q, cfg_d;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr)
        ecdcl_pkg::REG_RAW_POLARITY: cfg_d.raw_polarity = pwdata[0];
        ecdcl_pkg::REG_DEBOUNCE_EN:  cfg_d.debounce_en  = pwdata[0];
        default:                     cfg_d = cfg_q;  // unmapped, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{raw_polarity: 1'b0, debounce_en: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr)
      ecdcl_pkg::REG_RAW_POLARITY:
        prdata = {{(ecdcl_pkg::APB_DW-1){1'b0}}, cfg_q.raw_polarity};
      ecdcl_pkg::REG_DEBOUNCE_EN:
        prdata = {{(ecdcl_pkg::APB_DW-1){1'b0}}, cfg_q.debounce_en};
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the state registers double as the result register, so a new
  // transaction is taken whenever the held result is gone or leaving now.
  // --------------------------------------------------------------------------
  logic               accept;
  logic               sample;
  logic               out_valid_q;
  ecdcl_pkg::opcode_e opcode;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign opcode        = ecdcl_pkg::opcode_e'(s_axis_tuser);
  assign sample        = accept && (opcode == ecdcl_pkg::OP_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: conditioning + window vote, then change latch
  // --------------------------------------------------------------------------
  logic [ecdcl_pkg::PIN_W-1:0] filtered_next;
  ecdcl_pkg::status_t          status;

  ecdcl_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample),
    .cfg_i      (cfg_q),
    .pins_i     (s_axis_tdata),
    .filtered_o (filtered_next)
  );

  ecdcl_latch u_latch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode),
    .filtered_i (filtered_next),
    .status_o   (status)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, status.mask, status.value, status.pending,
                          status.filtered};

`ifndef ASSERT_OFF
  // A pending event always carries the nonzero mask that raised it.
  a_pending_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pending |-> (status.mask != '0))
    else $error("pending event with empty change mask");

  // An accepted acknowledge clears pending.
  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode == ecdcl_pkg::OP_ACK) |=> !status.pending)
    else $error("acknowledge did not clear pending");

  // Samples taken while pending leave the latched event and mask alone.
  a_hold_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample && status.pending) |=> ($stable(status.value) && $stable(status.mask)))
    else $error("latched event changed while pending");
`endif

endmodule

@@ hdl/ecdcl_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdcl_filter
// Per-channel polarity conditioning and 5-sample window filter voting on the four newest.
// ----------------------------------------------------------------------------
module ecdcl_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_i,   // sample transaction accepted
  input  ecdcl_pkg::cfg_t           cfg_i,
  input  logic [ecdcl_pkg::PIN_W-1:0] pins_i,
  output logic [ecdcl_pkg::PIN_W-1:0] filtered_o  // next filtered state
);

  logic [ecdcl_pkg::PIN_W-1:0] level;

  assign level = cfg_i.raw_polarity ? pins_i : ~pins_i;

  for (genvar k = 0; k < ecdcl_pkg::PIN_W; k++) begin : g_ch
    if (k < ecdcl_pkg::CHANNELS) begin : g_on
      logic [ecdcl_pkg::WIN_W-1:0] win_q;
      logic [ecdcl_pkg::WIN_W-1:0] win_d;

      // newest sample enters bit 0
      assign win_d = {win_q[ecdcl_pkg::WIN_W-2:0], level[k]};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          win_q <= '0;
        end else if (sample_i && cfg_i.debounce_en) begin
          win_q <= win_d;
        end
      end

      assign filtered_o[k] = cfg_i.debounce_en ? ecdcl_pkg::VOTE_TABLE[win_d[3:0]]
                                               : level[k];
    end else begin : g_off
      assign filtered_o[k] = 1'b0;
    end
  end

endmodule

@@ hdl/ecdcl_latch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdcl_latch
// Filtered state register, change detection and pending event latch.
// ----------------------------------------------------------------------------
module ecdcl_latch (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  ecdcl_pkg::opcode_e          opcode_i,
  input  logic [ecdcl_pkg::PIN_W-1:0] filtered_i,
  output ecdcl_pkg::status_t          status_o
);

  logic [ecdcl_pkg::PIN_W-1:0] filtered_q, filtered_d;
  logic [ecdcl_pkg::PIN_W-1:0] value_q, value_d;
  logic [ecdcl_pkg::PIN_W-1:0] mask_q, mask_d;
  logic                        pending_q, pending_d;
  logic [ecdcl_pkg::PIN_W-1:0] diff;

  assign diff = filtered_i ^ value_q;

  always_comb begin
    filtered_d = filtered_q;
    value_d    = value_q;
    mask_d     = mask_q;
    pending_d  = pending_q;
    if (accept_i) begin
      case (opcode_i)
        ecdcl_pkg::OP_ACK: begin
          pending_d = 1'b0;
        end
        ecdcl_pkg::OP_SAMPLE: begin
          filtered_d = filtered_i;
          if (!pending_q) begin
            mask_d = diff;
            if (diff != '0) begin
              value_d   = filtered_i;
              pending_d = 1'b1;
            end
          end
        end
        default: begin
          pending_d = pending_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filtered_q <= '0;
      value_q    <= '0;
      mask_q     <= '0;
      pending_q  <= 1'b0;
    end else begin
      filtered_q <= filtered_d;
      value_q    <= value_d;
      mask_q     <= mask_d;
      pending_q  <= pending_d;
    end
  end

  assign status_o = '{filtered: filtered_q, pending: pending_q,
                      value: value_q, mask: mask_q};

endmodule
